// File: rtl/core/tcrc_pkg.sv
`default_nettype none
package tcrc_pkg;

  localparam int LAMP_COUNT = 16;
  localparam int CFG_ADDR_W = 5;

  localparam logic [15:0] MASK_TICKS_RST    = 16'd50;
  localparam logic [15:0] ALIVE_RELOAD_RST  = 16'd10;
  localparam logic [15:0] ALIVE_EXPIRED_RST = 16'd0;
  localparam logic [15:0] CRC_RELOAD_RST    = 16'd10;
  localparam logic [15:0] CRC_EXPIRED_RST   = 16'd0;

  localparam logic [2:0] REG_MASK_TICKS    = 3'd0;
  localparam logic [2:0] REG_ALIVE_RELOAD  = 3'd1;
  localparam logic [2:0] REG_ALIVE_EXPIRED = 3'd2;
  localparam logic [2:0] REG_CRC_RELOAD    = 3'd3;
  localparam logic [2:0] REG_CRC_EXPIRED   = 3'd4;

  localparam logic [1:0] KIND_STEADY = 2'd1;
  localparam logic [1:0] KIND_BLINK  = 2'd2;

  typedef enum logic [1:0] {
    CMD_ALIVE = 2'd0,
    CMD_CRC   = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_CHECK = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    BL_OK       = 2'd0,
    BL_OFF_WAIT = 2'd1,
    BL_ON_WAIT  = 2'd2,
    BL_BOTH_BAD = 2'd3
  } blink_state_t;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] alive_value;
    logic [3:0]  lamp_index;
    logic [31:0] crc_reading;
    logic        power_ready;
    logic [1:0]  request_kind;
    logic [31:0] expected_crc;
    logic [7:0]  blink_period;
    logic        last_lamp;
  } item_t;

  typedef struct packed {
    logic masked;
    logic alive_fail;
    logic lamp_mismatch;
    logic lamp_expired;
    logic crc_fail_action;
  } result_t;

  typedef struct packed {
    logic [15:0] mask_ticks;
    logic [15:0] alive_reload;
    logic [15:0] alive_expired;
    logic [15:0] crc_reload;
    logic [15:0] crc_expired;
  } cfg_t;

  function automatic logic [15:0] debounce_next(input logic [15:0] cur, input logic good,
                                                input logic [15:0] reload,
                                                input logic [15:0] floor_v);
    logic [15:0] r;
    if (good) begin
      r = reload;
    end else if (cur > reload) begin
      r = reload - 16'd1;
    end else if (cur > floor_v) begin
      r = cur - 16'd1;
    end else begin
      r = floor_v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/tcrc_cfg_regs.sv
`default_nettype none
module tcrc_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tcrc_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output tcrc_pkg::cfg_t                       cfg
);

  logic       wr;
  logic [2:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mask_ticks    <= tcrc_pkg::MASK_TICKS_RST;
      cfg.alive_reload  <= tcrc_pkg::ALIVE_RELOAD_RST;
      cfg.alive_expired <= tcrc_pkg::ALIVE_EXPIRED_RST;
      cfg.crc_reload    <= tcrc_pkg::CRC_RELOAD_RST;
      cfg.crc_expired   <= tcrc_pkg::CRC_EXPIRED_RST;
    end else if (wr) begin
      case (idx)
        tcrc_pkg::REG_MASK_TICKS:    cfg.mask_ticks    <= pwdata[15:0];
        tcrc_pkg::REG_ALIVE_RELOAD:  cfg.alive_reload  <= pwdata[15:0];
        tcrc_pkg::REG_ALIVE_EXPIRED: cfg.alive_expired <= pwdata[15:0];
        tcrc_pkg::REG_CRC_RELOAD:    cfg.crc_reload    <= pwdata[15:0];
        tcrc_pkg::REG_CRC_EXPIRED:   cfg.crc_expired   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tcrc_pkg::REG_MASK_TICKS:    prdata = {16'd0, cfg.mask_ticks};
      tcrc_pkg::REG_ALIVE_RELOAD:  prdata = {16'd0, cfg.alive_reload};
      tcrc_pkg::REG_ALIVE_EXPIRED: prdata = {16'd0, cfg.alive_expired};
      tcrc_pkg::REG_CRC_RELOAD:    prdata = {16'd0, cfg.crc_reload};
      tcrc_pkg::REG_CRC_EXPIRED:   prdata = {16'd0, cfg.crc_expired};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/tcrc_core.sv
`default_nettype none
module tcrc_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire tcrc_pkg::item_t  item,
  input  wire tcrc_pkg::cfg_t   cfg,
  output tcrc_pkg::result_t     res
);

  logic [15:0] mask_count, mask_count_next;
  logic        checks_enabled, checks_enabled_next;
  logic [31:0] alive_previous, alive_previous_next;
  logic [31:0] alive_current, alive_current_next;
  logic [15:0] alive_debounce, alive_debounce_next;
  logic        tick_any_expired, tick_any_expired_next;

  logic [31:0]            lamp_crc_store [tcrc_pkg::LAMP_COUNT];
  logic [7:0]             blink_phase    [tcrc_pkg::LAMP_COUNT];
  tcrc_pkg::blink_state_t blink_state    [tcrc_pkg::LAMP_COUNT];
  logic [15:0]            lamp_debounce  [tcrc_pkg::LAMP_COUNT];

  logic                   do_clear;
  logic                   crc_wr;
  logic                   lamp_wr;
  logic                   in_range;
  logic [3:0]             idx;
  logic [31:0]            seen;
  logic [31:0]            want;
  logic [7:0]             phase_cur;
  tcrc_pkg::blink_state_t st_cur;
  tcrc_pkg::blink_state_t st_blink;
  tcrc_pkg::blink_state_t st_new;
  logic [7:0]             phase_blink;
  logic [7:0]             phase_new;
  logic                   good;
  logic [15:0]            deb_new;

  assign idx       = item.lamp_index;
  assign in_range  = int'(idx) < tcrc_pkg::LAMP_COUNT;
  assign seen      = lamp_crc_store[idx];
  assign phase_cur = blink_phase[idx];
  assign st_cur    = blink_state[idx];
  assign want      = (phase_cur < (item.blink_period >> 1)) ? item.expected_crc : 32'd0;

  // blink on/off phase machine
  always_comb begin
    st_blink = st_cur;
    case (st_cur)
      tcrc_pkg::BL_OK: begin
        if (seen != want) st_blink = tcrc_pkg::BL_BOTH_BAD;
      end
      tcrc_pkg::BL_OFF_WAIT: begin
        if (want == 32'd0 && seen == want) st_blink = tcrc_pkg::BL_OK;
      end
      tcrc_pkg::BL_ON_WAIT: begin
        if (want == item.expected_crc && seen == want) st_blink = tcrc_pkg::BL_OK;
      end
      default: begin
        if (seen == want) begin
          st_blink = (want == 32'd0) ? tcrc_pkg::BL_ON_WAIT : tcrc_pkg::BL_OFF_WAIT;
        end
      end
    endcase
    if (item.blink_period == 8'd0 || phase_cur >= item.blink_period - 8'd1) begin
      phase_blink = 8'd0;
    end else begin
      phase_blink = phase_cur + 8'd1;
    end
  end

  always_comb begin
    case (item.request_kind)
      tcrc_pkg::KIND_STEADY: begin
        good      = (seen == item.expected_crc);
        st_new    = tcrc_pkg::BL_OK;
        phase_new = 8'd0;
      end
      tcrc_pkg::KIND_BLINK: begin
        good      = (st_blink == tcrc_pkg::BL_OK);
        st_new    = st_blink;
        phase_new = phase_blink;
      end
      default: begin
        good      = 1'b1;
        st_new    = tcrc_pkg::BL_OK;
        phase_new = 8'd0;
      end
    endcase
    deb_new = tcrc_pkg::debounce_next(lamp_debounce[idx], good, cfg.crc_reload,
                                      cfg.crc_expired);
  end

  always_comb begin
    mask_count_next       = mask_count;
    checks_enabled_next   = checks_enabled;
    alive_previous_next   = alive_previous;
    alive_current_next    = alive_current;
    alive_debounce_next   = alive_debounce;
    tick_any_expired_next = tick_any_expired;
    do_clear              = 1'b0;
    crc_wr                = 1'b0;
    lamp_wr               = 1'b0;
    res                   = '0;
    case (item.command)
      tcrc_pkg::CMD_ALIVE: begin
        alive_current_next = item.alive_value;
      end
      tcrc_pkg::CMD_CRC: begin
        crc_wr = in_range;
      end
      tcrc_pkg::CMD_TICK: begin
        if (!item.power_ready || mask_count < cfg.mask_ticks) begin
          do_clear   = 1'b1;
          res.masked = 1'b1;
          if (!item.power_ready) begin
            mask_count_next = 16'd0;
          end else if (mask_count != 16'hFFFF) begin
            mask_count_next = mask_count + 16'd1;
          end
          alive_previous_next   = '1;
          alive_debounce_next   = cfg.alive_reload;
          checks_enabled_next   = 1'b0;
          tick_any_expired_next = 1'b0;
        end else begin
          alive_debounce_next   = tcrc_pkg::debounce_next(alive_debounce,
                                    alive_previous != alive_current,
                                    cfg.alive_reload, cfg.alive_expired);
          alive_previous_next   = alive_current;
          res.alive_fail        = (alive_debounce_next == cfg.alive_expired);
          checks_enabled_next   = 1'b1;
          tick_any_expired_next = 1'b0;
          mask_count_next       = cfg.mask_ticks;
        end
      end
      default: begin
        if (checks_enabled) begin
          if (in_range) begin
            lamp_wr           = 1'b1;
            res.lamp_mismatch = !good;
            if (deb_new == cfg.crc_expired) begin
              res.lamp_expired      = 1'b1;
              tick_any_expired_next = 1'b1;
            end
          end
          res.crc_fail_action = item.last_lamp && tick_any_expired_next;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_count       <= 16'd0;
      checks_enabled   <= 1'b0;
      alive_previous   <= '1;
      alive_current    <= '1;
      alive_debounce   <= tcrc_pkg::ALIVE_RELOAD_RST;
      tick_any_expired <= 1'b0;
      for (int i = 0; i < tcrc_pkg::LAMP_COUNT; i++) begin
        lamp_crc_store[i] <= '1;
        blink_phase[i]    <= 8'd0;
        blink_state[i]    <= tcrc_pkg::BL_OK;
        lamp_debounce[i]  <= tcrc_pkg::CRC_RELOAD_RST;
      end
    end else if (step) begin
      mask_count       <= mask_count_next;
      checks_enabled   <= checks_enabled_next;
      alive_previous   <= alive_previous_next;
      alive_current    <= alive_current_next;
      alive_debounce   <= alive_debounce_next;
      tick_any_expired <= tick_any_expired_next;
      if (do_clear) begin
        for (int i = 0; i < tcrc_pkg::LAMP_COUNT; i++) begin
          lamp_crc_store[i] <= '1;
          blink_phase[i]    <= 8'd0;
          blink_state[i]    <= tcrc_pkg::BL_OK;
          lamp_debounce[i]  <= cfg.crc_reload;
        end
      end else begin
        if (crc_wr) lamp_crc_store[idx] <= item.crc_reading;
        if (lamp_wr) begin
          blink_phase[idx]   <= phase_new;
          blink_state[idx]   <= st_new;
          lamp_debounce[idx] <= deb_new;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/telltale_crc_alive_monitor_top.sv
// an accepted transaction waits in the input register, its result in the result register
// throughput: one transaction per cycle while out_ready is high, set by the core update
// stalls: the input register and the result register each hold one transaction
// reset: synchronous, active high; all state but the input and result data words resets
`default_nettype none
module telltale_crc_alive_monitor_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tcrc_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      command,
  input  wire logic [31:0]                     alive_value,
  input  wire logic [3:0]                      lamp_index,
  input  wire logic [31:0]                     crc_reading,
  input  wire logic                            power_ready,
  input  wire logic [1:0]                      request_kind,
  input  wire logic [31:0]                     expected_crc,
  input  wire logic [7:0]                      blink_period,
  input  wire logic                            last_lamp,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 masked,
  output logic                                 alive_fail,
  output logic                                 lamp_mismatch,
  output logic                                 lamp_expired,
  output logic                                 crc_fail_action
);

  tcrc_pkg::cfg_t    cfg;
  tcrc_pkg::item_t   item_d;
  tcrc_pkg::item_t   item_q;
  tcrc_pkg::result_t res_d;
  tcrc_pkg::result_t res_q;
  logic              item_valid;
  logic              advance;

  assign pready = 1'b1;

  tcrc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign item_d.command      = tcrc_pkg::cmd_t'(command);
  assign item_d.alive_value  = alive_value;
  assign item_d.lamp_index   = lamp_index;
  assign item_d.crc_reading  = crc_reading;
  assign item_d.power_ready  = power_ready;
  assign item_d.request_kind = request_kind;
  assign item_d.expected_crc = expected_crc;
  assign item_d.blink_period = blink_period;
  assign item_d.last_lamp    = last_lamp;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_q <= item_d;
  end

  tcrc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item_q),
    .cfg  (cfg),
    .res  (res_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_q <= res_d;
  end

  assign masked          = res_q.masked;
  assign alive_fail      = res_q.alive_fail;
  assign lamp_mismatch   = res_q.lamp_mismatch;
  assign lamp_expired    = res_q.lamp_expired;
  assign crc_fail_action = res_q.crc_fail_action;

`ifndef SYNTHESIS
  a_masked_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && masked |-> !alive_fail && !lamp_mismatch && !lamp_expired && !crc_fail_action)
    else $error("masked result carries other flags");

  a_alive_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && alive_fail |-> !lamp_mismatch && !lamp_expired && !crc_fail_action)
    else $error("alive failure mixed with lamp flags");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && !advance |=> item_valid && $stable(item_q))
    else $error("stalled input register lost its transaction");
`endif

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] KIND_OFF      = 2'd0;
  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         HOLD_CYCLES   = 300;

  class lamp_monitor_scoreboard;
    logic [15:0]            cfg_mask, cfg_alive_reload, cfg_alive_expired;
    logic [15:0]            cfg_crc_reload, cfg_crc_expired;
    logic [15:0]            mask_count;
    bit                     checks_on;
    logic [31:0]            alive_prev, alive_cur;
    logic [15:0]            alive_count;
    logic [31:0]            crc_seen [tcrc_pkg::LAMP_COUNT];
    logic [7:0]             phase [tcrc_pkg::LAMP_COUNT];
    tcrc_pkg::blink_state_t bstate [tcrc_pkg::LAMP_COUNT];
    logic [15:0]            lamp_count [tcrc_pkg::LAMP_COUNT];
    bit                     any_expired;
    tcrc_pkg::result_t      expected_results [$];
    int                     mismatches;

    function new();
      cfg_mask          = tcrc_pkg::MASK_TICKS_RST;
      cfg_alive_reload  = tcrc_pkg::ALIVE_RELOAD_RST;
      cfg_alive_expired = tcrc_pkg::ALIVE_EXPIRED_RST;
      cfg_crc_reload    = tcrc_pkg::CRC_RELOAD_RST;
      cfg_crc_expired   = tcrc_pkg::CRC_EXPIRED_RST;
      wipe();
      mask_count = 16'd0;
      alive_cur  = '1;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] value);
      case (idx)
        tcrc_pkg::REG_MASK_TICKS:    cfg_mask = value;
        tcrc_pkg::REG_ALIVE_RELOAD:  cfg_alive_reload = value;
        tcrc_pkg::REG_ALIVE_EXPIRED: cfg_alive_expired = value;
        tcrc_pkg::REG_CRC_RELOAD:    cfg_crc_reload = value;
        tcrc_pkg::REG_CRC_EXPIRED:   cfg_crc_expired = value;
        default: ;
      endcase
    endfunction

    function void wipe();
      alive_prev  = '1;
      alive_count = cfg_alive_reload;
      for (int i = 0; i < tcrc_pkg::LAMP_COUNT; i++) begin
        crc_seen[i]   = '1;
        phase[i]      = 8'd0;
        bstate[i]     = tcrc_pkg::BL_OK;
        lamp_count[i] = cfg_crc_reload;
      end
      checks_on   = 1'b0;
      any_expired = 1'b0;
    endfunction

    function logic [15:0] next_count(logic [15:0] cur, bit good, logic [15:0] reload,
                                     logic [15:0] lowest);
      if (good) return reload;
      if (cur > reload) return reload - 16'd1;
      if (cur > lowest) return cur - 16'd1;
      return lowest;
    endfunction

    function bit blink_update(int i, logic [31:0] on_crc, logic [7:0] period);
      logic [31:0]            want_crc;
      tcrc_pkg::blink_state_t st;
      want_crc = (phase[i] < (period >> 1)) ? on_crc : 32'd0;
      st = bstate[i];
      case (st)
        tcrc_pkg::BL_OK: begin
          if (crc_seen[i] != want_crc) st = tcrc_pkg::BL_BOTH_BAD;
        end
        tcrc_pkg::BL_OFF_WAIT: begin
          if (want_crc == 32'd0 && crc_seen[i] == want_crc) st = tcrc_pkg::BL_OK;
        end
        tcrc_pkg::BL_ON_WAIT: begin
          if (want_crc == on_crc && crc_seen[i] == want_crc) st = tcrc_pkg::BL_OK;
        end
        default: begin
          if (crc_seen[i] == want_crc) begin
            if (want_crc == 32'd0) st = tcrc_pkg::BL_ON_WAIT;
            else st = tcrc_pkg::BL_OFF_WAIT;
          end
        end
      endcase
      bstate[i] = st;
      if (period == 8'd0 || phase[i] >= period - 8'd1) phase[i] = 8'd0;
      else phase[i] = phase[i] + 8'd1;
      return st == tcrc_pkg::BL_OK;
    endfunction

    function void note_item(tcrc_pkg::item_t it);
      tcrc_pkg::result_t r;
      bit                ok;
      int                i;
      r = '0;
      i = it.lamp_index;
      case (it.command)
        tcrc_pkg::CMD_ALIVE: alive_cur = it.alive_value;
        tcrc_pkg::CMD_CRC:   crc_seen[i] = it.crc_reading;
        tcrc_pkg::CMD_TICK: begin
          if (!it.power_ready) begin
            wipe();
            mask_count = 16'd0;
            r.masked = 1'b1;
          end else if (mask_count < cfg_mask) begin
            wipe();
            if (mask_count != 16'hFFFF) mask_count = mask_count + 16'd1;
            r.masked = 1'b1;
          end else begin
            alive_count = next_count(alive_count, alive_prev != alive_cur,
                                     cfg_alive_reload, cfg_alive_expired);
            alive_prev   = alive_cur;
            r.alive_fail = (alive_count == cfg_alive_expired);
            checks_on    = 1'b1;
            any_expired  = 1'b0;
            mask_count   = cfg_mask;
          end
        end
        default: begin
          if (checks_on) begin
            if (it.request_kind == tcrc_pkg::KIND_STEADY) begin
              ok = (crc_seen[i] == it.expected_crc);
              bstate[i] = tcrc_pkg::BL_OK;
              phase[i] = 8'd0;
            end else if (it.request_kind == tcrc_pkg::KIND_BLINK) begin
              ok = blink_update(i, it.expected_crc, it.blink_period);
            end else begin
              ok = 1'b1;
              bstate[i] = tcrc_pkg::BL_OK;
              phase[i] = 8'd0;
            end
            lamp_count[i] = next_count(lamp_count[i], ok, cfg_crc_reload, cfg_crc_expired);
            r.lamp_mismatch = !ok;
            if (lamp_count[i] == cfg_crc_expired) begin
              r.lamp_expired = 1'b1;
              any_expired = 1'b1;
            end
            if (it.last_lamp) r.crc_fail_action = any_expired;
          end
        end
      endcase
      expected_results.push_back(r);
    endfunction

    function void check_result(tcrc_pkg::result_t got);
      tcrc_pkg::result_t want;
      if (expected_results.size() == 0) begin
        if (mismatches < 10) $display("result with nothing pending: %b", got);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.masked !== want.masked || got.alive_fail !== want.alive_fail ||
          got.lamp_mismatch !== want.lamp_mismatch || got.lamp_expired !== want.lamp_expired ||
          got.crc_fail_action !== want.crc_fail_action) begin
        if (mismatches < 10) begin
          $display("result mismatch at %0t: masked/alive_fail/lamp_mismatch/lamp_expired/%s",
                   $realtime, "crc_fail_action");
          $display("  expected %b %b %b %b %b, got %b %b %b %b %b", want.masked,
                   want.alive_fail, want.lamp_mismatch, want.lamp_expired,
                   want.crc_fail_action, got.masked, got.alive_fail, got.lamp_mismatch,
                   got.lamp_expired, got.crc_fail_action);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            psel, penable, pwrite;
  logic [tcrc_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0]                     pwdata;
  logic [31:0]                     apb_rdata;
  logic                            pready;
  logic                            in_valid, in_ready;
  tcrc_pkg::item_t                 drv;
  logic                            out_valid, out_ready;
  logic                            masked, alive_fail, lamp_mismatch, lamp_expired;
  logic                            crc_fail_action;

  lamp_monitor_scoreboard sb;
  bit          no_idle;
  bit          hold_request;
  bit          hold_done;
  int          hold_left;
  int          items_sent;
  int          cycles;
  logic [31:0] alive_seq;
  bit          alive_frozen;
  logic [31:0] lamp_on_crc [16];
  logic [7:0]  lamp_period [16];
  logic [1:0]  lamp_kind [16];

  telltale_crc_alive_monitor_top u_top (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (apb_rdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (drv.command),
    .alive_value     (drv.alive_value),
    .lamp_index      (drv.lamp_index),
    .crc_reading     (drv.crc_reading),
    .power_ready     (drv.power_ready),
    .request_kind    (drv.request_kind),
    .expected_crc    (drv.expected_crc),
    .blink_period    (drv.blink_period),
    .last_lamp       (drv.last_lamp),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .masked          (masked),
    .alive_fail      (alive_fail),
    .lamp_mismatch   (lamp_mismatch),
    .lamp_expired    (lamp_expired),
    .crc_fail_action (crc_fail_action)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side first so a stray result is never hidden by a same-edge transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_result({masked, alive_fail, lamp_mismatch, lamp_expired, crc_fail_action});
      if (in_valid && in_ready) sb.note_item(drv);
    end
  end

  always @(posedge clk) begin
    if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 22);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic send_item(input tcrc_pkg::item_t it);
    while (!no_idle && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    drv <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // let the monitor note a transaction accepted at this edge before looking at the queue
  task automatic wait_drained();
    in_valid <= 1'b0;
    #1;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic apply_settings(input logic [15:0] mask, input logic [15:0] a_reload,
                                input logic [15:0] a_expired, input logic [15:0] c_reload,
                                input logic [15:0] c_expired);
    write_reg(tcrc_pkg::REG_MASK_TICKS, mask);
    write_reg(tcrc_pkg::REG_ALIVE_RELOAD, a_reload);
    write_reg(tcrc_pkg::REG_ALIVE_EXPIRED, a_expired);
    write_reg(tcrc_pkg::REG_CRC_RELOAD, c_reload);
    write_reg(tcrc_pkg::REG_CRC_EXPIRED, c_expired);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic tcrc_pkg::item_t build_item(tcrc_pkg::cmd_t cmd, logic [3:0] lamp,
                                                 logic [31:0] value, logic [1:0] kind,
                                                 logic [7:0] period, logic pwr, logic last);
    tcrc_pkg::item_t it;
    it = '0;
    it.command      = cmd;
    it.lamp_index   = lamp;
    it.alive_value  = (cmd == tcrc_pkg::CMD_ALIVE) ? value : 32'd0;
    it.crc_reading  = (cmd == tcrc_pkg::CMD_CRC) ? value : 32'd0;
    it.expected_crc = (cmd == tcrc_pkg::CMD_CHECK) ? value : 32'd0;
    it.request_kind = kind;
    it.blink_period = period;
    it.power_ready  = pwr;
    it.last_lamp    = last;
    return it;
  endfunction

  task automatic plan_lamps();
    logic [7:0] periods [8];
    periods = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd6, 8'd8, 8'd255};
    for (int i = 0; i < 16; i++) begin
      case ($urandom_range(5))
        0:       lamp_on_crc[i] = 32'd0;
        1:       lamp_on_crc[i] = '1;
        default: lamp_on_crc[i] = $urandom;
      endcase
      lamp_kind[i]   = 2'($urandom_range(3));
      lamp_period[i] = periods[$urandom_range(7)];
    end
  endtask

  // one tick: optional alive record, the tick, then lamp records, checks and noise items
  task automatic send_frame();
    tcrc_pkg::item_t it;
    logic [127:0]    noise;
    int              checks;
    int              lamp;
    if ($urandom_range(99) < 15) alive_frozen = !alive_frozen;
    if ($urandom_range(99) < 70) begin
      if ($urandom_range(9) == 0) alive_seq = $urandom;
      else if (!alive_frozen) alive_seq = alive_seq + 32'd1;
      send_item(build_item(tcrc_pkg::CMD_ALIVE, 4'd0, alive_seq, KIND_OFF, 8'd0, 1'b0,
                           1'b0));
    end
    send_item(build_item(tcrc_pkg::CMD_TICK, 4'd0, 32'd0, KIND_OFF, 8'd0,
                         $urandom_range(19) != 0, 1'b0));
    checks = $urandom_range(4);
    for (int k = 0; k < checks; k++) begin
      lamp = ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(15);
      if ($urandom_range(99) < 80) begin
        it = build_item(tcrc_pkg::CMD_CRC, 4'(lamp), lamp_on_crc[lamp], KIND_OFF, 8'd0,
                        1'b0, 1'b0);
        case ($urandom_range(9))
          5, 6, 7: it.crc_reading = 32'd0;
          8, 9:    it.crc_reading = $urandom;
          default: ;
        endcase
        send_item(it);
      end
      it = build_item(tcrc_pkg::CMD_CHECK, 4'(lamp), lamp_on_crc[lamp], lamp_kind[lamp],
                      lamp_period[lamp], 1'b0, k == checks - 1);
      if ($urandom_range(99) < 15) it.request_kind = 2'($urandom_range(3));
      if ($urandom_range(9) == 0) it.expected_crc = $urandom;
      if ($urandom_range(9) == 0) it.blink_period = 8'($urandom_range(255));
      send_item(it);
      if ($urandom_range(99) < 8) begin
        noise = {$urandom, $urandom, $urandom, $urandom};
        send_item(noise[$bits(tcrc_pkg::item_t)-1:0]);
      end
    end
  endtask

  task automatic run_phase(input int quota, input bit quiet, input bit hold);
    int start;
    start   = items_sent;
    no_idle = quiet;
    if (hold) hold_request <= 1'b1;
    plan_lamps();
    while (items_sent - start < quota) send_frame();
    wait_drained();
    no_idle = 1'b0;
  endtask

  initial begin
    sb = new();
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    drv          <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    out_ready    <= 1'b0;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    hold_done    = 1'b0;
    hold_left    = 0;
    items_sent   = 0;
    alive_seq    = 32'd0;
    alive_frozen = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: check before any tick, then a power-off tick
    send_item(build_item(tcrc_pkg::CMD_CHECK, 4'd0, '1, tcrc_pkg::KIND_STEADY, 8'd0, 1'b0,
                         1'b1));
    send_item(build_item(tcrc_pkg::CMD_TICK, 4'd0, 32'd0, KIND_OFF, 8'd0, 1'b0, 1'b0));
    wait_drained();

    apply_settings(16'd1, 16'd2, 16'd0, 16'd1, 16'd0);
    send_item(build_item(tcrc_pkg::CMD_TICK, 4'd0, 32'd0, KIND_OFF, 8'd0, 1'b1, 1'b0));
    send_item(build_item(tcrc_pkg::CMD_ALIVE, 4'd0, '1, KIND_OFF, 8'd0, 1'b0, 1'b0));
    send_item(build_item(tcrc_pkg::CMD_CRC, 4'd0, '1, KIND_OFF, 8'd0, 1'b0, 1'b0));
    send_item(build_item(tcrc_pkg::CMD_CRC, 4'd15, 32'd0, KIND_OFF, 8'd0, 1'b0, 1'b0));
    // frozen alive counter on the first enabled tick
    send_item(build_item(tcrc_pkg::CMD_TICK, 4'd0, 32'd0, KIND_OFF, 8'd0, 1'b1, 1'b0));
    send_item(build_item(tcrc_pkg::CMD_CHECK, 4'd0, '1, tcrc_pkg::KIND_STEADY, 8'd0, 1'b0,
                         1'b0));
    send_item(build_item(tcrc_pkg::CMD_CHECK, 4'd15, 32'h1234_5678, tcrc_pkg::KIND_STEADY,
                         8'd0, 1'b0, 1'b0));
    send_item(build_item(tcrc_pkg::CMD_CHECK, 4'd3, 32'd0, KIND_OFF, 8'd0, 1'b0, 1'b0));
    send_item(build_item(tcrc_pkg::CMD_CHECK, 4'd4, 32'd0, KIND_RESERVED, 8'd0, 1'b0, 1'b0));
    send_item(build_item(tcrc_pkg::CMD_CHECK, 4'd5, 32'd0, tcrc_pkg::KIND_BLINK, 8'd0, 1'b0,
                         1'b0));
    send_item(build_item(tcrc_pkg::CMD_CHECK, 4'd15, 32'd0, tcrc_pkg::KIND_BLINK, 8'd255,
                         1'b0, 1'b1));
    send_item(build_item(tcrc_pkg::CMD_ALIVE, 4'd0, 32'd0, KIND_OFF, 8'd0, 1'b0, 1'b0));
    send_item(build_item(tcrc_pkg::CMD_TICK, 4'd0, 32'd0, KIND_OFF, 8'd0, 1'b1, 1'b0));
    send_item(build_item(tcrc_pkg::CMD_TICK, 4'd0, 32'd0, KIND_OFF, 8'd0, 1'b1, 1'b0));
    send_item(build_item(tcrc_pkg::CMD_TICK, 4'd0, 32'd0, KIND_OFF, 8'd0, 1'b1, 1'b0));
    // two-tick blink: lit half, dark half, then a dark reading in the lit half
    send_item(build_item(tcrc_pkg::CMD_CRC, 4'd6, 32'hA5A5_A5A5, KIND_OFF, 8'd0, 1'b0, 1'b0));
    send_item(build_item(tcrc_pkg::CMD_CHECK, 4'd6, 32'hA5A5_A5A5, tcrc_pkg::KIND_BLINK,
                         8'd2, 1'b0, 1'b0));
    send_item(build_item(tcrc_pkg::CMD_CRC, 4'd6, 32'd0, KIND_OFF, 8'd0, 1'b0, 1'b0));
    send_item(build_item(tcrc_pkg::CMD_CHECK, 4'd6, 32'hA5A5_A5A5, tcrc_pkg::KIND_BLINK,
                         8'd2, 1'b0, 1'b1));
    send_item(build_item(tcrc_pkg::CMD_CHECK, 4'd6, 32'hA5A5_A5A5, tcrc_pkg::KIND_BLINK,
                         8'd2, 1'b0, 1'b1));
    send_item(build_item(tcrc_pkg::CMD_TICK, 4'd0, 32'd0, KIND_OFF, 8'd0, 1'b0, 1'b0));
    wait_drained();

    apply_settings(16'd3, 16'd4, 16'd1, 16'd3, 16'd0);
    run_phase(150, 1'b0, 1'b0);
    // zero reloads while counters still hold larger values
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_phase(100, 1'b1, 1'b0);
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(40, 1'b0, 1'b0);
    apply_settings(16'd2, 16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFD);
    run_phase(120, 1'b0, 1'b0);
    apply_settings(16'd4, 16'd5, 16'd3, 16'd7, 16'd5);
    run_phase(140, 1'b0, 1'b1);

    wait_drained();
    repeat (5) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/tcrc_pkg.sv
rtl/core/tcrc_cfg_regs.sv
rtl/core/tcrc_core.sv
rtl/core/telltale_crc_alive_monitor_top.sv
tb/tb_top.sv
